### design/eucdec_pkg.sv
// ============================================================================
// EUC decoder package
// Shared types and constants for the EUC byte to wide character decoder.
// ============================================================================
package eucdec_pkg;

    localparam int WC_W      = 32;
    localparam int LEN_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [7:0] BYTE_C1_FIRST = 8'h80;
    localparam logic [7:0] BYTE_C1_LAST  = 8'h9f;
    localparam logic [7:0] BYTE_SS2      = 8'h8e;
    localparam logic [7:0] BYTE_SS3      = 8'h8f;

    typedef enum logic [2:0] {
        CLS_EOS,
        CLS_ASCII,
        CLS_C1,
        CLS_SS2,
        CLS_SS3,
        CLS_HIGH
    } cls_t;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_ILLEGAL = 2'd1,
        KIND_EOS     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CS_NONE  = 2'd0,
        CS_ONE   = 2'd1,
        CS_TWO   = 2'd2,
        CS_THREE = 2'd3
    } codeset_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CS1_LEN = 3'd0,
        CFG_CS2_LEN = 3'd1,
        CFG_CS3_LEN = 3'd2,
        CFG_CS1_TAG = 3'd3,
        CFG_CS2_TAG = 3'd4,
        CFG_CS3_TAG = 3'd5
    } cfg_idx_t;

    localparam logic [WC_W-1:0] CS1_TAG_RESET = 32'h3000_0000;
    localparam logic [WC_W-1:0] CS2_TAG_RESET = 32'h1000_0000;
    localparam logic [WC_W-1:0] CS3_TAG_RESET = 32'h2000_0000;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] byte_value;
    } item_t;

endpackage

### design/eucdec_front.sv
// ============================================================================
// EUC decoder front end
// Accepts input transactions, classifies each byte and pushes the classified
// item into the queue.
// ============================================================================
module eucdec_front
    import eucdec_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_end_of_stream,
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    cls_t cls;

    always_comb begin
        if (s_end_of_stream) begin
            cls = CLS_EOS;
        end else if (s_byte_value < BYTE_C1_FIRST) begin
            cls = CLS_ASCII;
        end else if (s_byte_value == BYTE_SS2) begin
            cls = CLS_SS2;
        end else if (s_byte_value == BYTE_SS3) begin
            cls = CLS_SS3;
        end else if (s_byte_value <= BYTE_C1_LAST) begin
            cls = CLS_C1;
        end else begin
            cls = CLS_HIGH;
        end
    end

    assign s_ready           = q_ready;
    assign q_push            = s_valid & q_ready;
    assign q_item.cls        = cls;
    assign q_item.byte_value = s_byte_value;

endmodule

### design/eucdec_queue.sv
// ============================================================================
// EUC decoder item queue
// Short register queue that decouples the front end from the decode stage.
// ============================================================================
module eucdec_queue
    import eucdec_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/eucdec_back.sv
// ============================================================================
// EUC decoder back end
// Holds the configuration and the sequence state, decodes queued items and
// drives the registered result channel.
// ============================================================================
module eucdec_back
    import eucdec_pkg::*;
#(
    parameter int BITS_PER_BYTE_CODE = 7,
    parameter int MAX_SEQ_LEN        = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WC_W-1:0]      m_wide_char,
    output logic [1:0]           m_kind,
    output logic                 m_last_of_run
);

    localparam int BPB    = BITS_PER_BYTE_CODE;
    localparam int CODE_W = MAX_SEQ_LEN * BITS_PER_BYTE_CODE;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEQ_LEN);

    logic [LEN_W-1:0]  cs1_len_reg;
    logic [LEN_W-1:0]  cs2_len_reg;
    logic [LEN_W-1:0]  cs3_len_reg;
    logic [WC_W-1:0]   cs1_tag_reg;
    logic [WC_W-1:0]   cs2_tag_reg;
    logic [WC_W-1:0]   cs3_tag_reg;

    logic              in_seq_reg, in_seq_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [CODE_W-1:0] code_reg, code_next;
    codeset_t          cs_reg, cs_next;

    logic              m_valid_reg;
    logic [WC_W-1:0]   wc_reg;
    kind_t             kind_reg;
    logic              last_reg;

    logic              out_free;
    logic              proceed;
    logic              emit;
    logic [WC_W-1:0]   emit_wc;
    kind_t             emit_kind;
    logic              emit_last;

    logic              idle_emit;
    logic [WC_W-1:0]   idle_wc;
    kind_t             idle_kind;
    logic              idle_start;
    codeset_t          idle_cs;
    logic [LEN_W-1:0]  idle_rem;
    logic [CODE_W-1:0] idle_code;

    logic [BPB-1:0]        part;
    logic [LEN_W-1:0]      cs1_rem;
    logic [CODE_W+BPB-1:0] shifted;
    logic [CODE_W-1:0]     code_cont;
    logic [LEN_W-1:0]      rem_dec;
    logic [WC_W-1:0]       active_tag;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
        sat_len = (n > MAX_LEN) ? MAX_LEN : n;
    endfunction

    assign part      = q_item.byte_value[BPB-1:0];
    assign cs1_rem   = sat_len(cs1_len_reg) - 1'b1;
    assign shifted   = {code_reg, part};
    assign code_cont = shifted[CODE_W-1:0];
    assign rem_dec   = rem_reg - 1'b1;

    always_comb begin
        case (cs_reg)
            CS_TWO:   active_tag = cs2_tag_reg;
            CS_THREE: active_tag = cs3_tag_reg;
            default:  active_tag = cs1_tag_reg;
        endcase
    end

    // Handling of the head item as if the decoder were idle.
    always_comb begin
        idle_emit  = 1'b1;
        idle_wc    = WC_W'(q_item.byte_value);
        idle_kind  = KIND_CHAR;
        idle_start = 1'b0;
        idle_cs    = CS_ONE;
        idle_rem   = cs1_rem;
        idle_code  = CODE_W'(part);
        case (q_item.cls)
            CLS_EOS: begin
                idle_wc   = '0;
                idle_kind = KIND_EOS;
            end
            CLS_SS2: begin
                if (cs2_len_reg != '0) begin
                    idle_emit  = 1'b0;
                    idle_start = 1'b1;
                    idle_cs    = CS_TWO;
                    idle_rem   = sat_len(cs2_len_reg);
                    idle_code  = '0;
                end
            end
            CLS_SS3: begin
                if (cs3_len_reg != '0) begin
                    idle_emit  = 1'b0;
                    idle_start = 1'b1;
                    idle_cs    = CS_THREE;
                    idle_rem   = sat_len(cs3_len_reg);
                    idle_code  = '0;
                end
            end
            CLS_HIGH: begin
                if (cs1_len_reg != '0) begin
                    if (cs1_rem == '0) begin
                        idle_wc = WC_W'(part) | cs1_tag_reg;
                    end else begin
                        idle_emit  = 1'b0;
                        idle_start = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        emit        = 1'b0;
        emit_wc     = '0;
        emit_kind   = KIND_CHAR;
        emit_last   = 1'b1;
        q_pop       = 1'b0;
        in_seq_next = in_seq_reg;
        rem_next    = rem_reg;
        code_next   = code_reg;
        cs_next     = cs_reg;
        out_free    = !m_valid_reg || m_ready;

        if (in_seq_reg) begin
            if (q_item.cls == CLS_HIGH) begin
                q_pop     = 1'b1;
                rem_next  = rem_dec;
                code_next = code_cont;
                if (rem_dec == '0) begin
                    emit        = 1'b1;
                    emit_wc     = WC_W'(code_cont) | active_tag;
                    in_seq_next = 1'b0;
                    cs_next     = CS_NONE;
                end
            end else begin
                emit      = 1'b1;
                emit_kind = KIND_ILLEGAL;
                if (idle_emit) begin
                    // The item gets its own result on the next pass.
                    emit_last   = 1'b0;
                    in_seq_next = 1'b0;
                    rem_next    = '0;
                    code_next   = '0;
                    cs_next     = CS_NONE;
                end else begin
                    q_pop       = 1'b1;
                    in_seq_next = 1'b1;
                    rem_next    = idle_rem;
                    code_next   = idle_code;
                    cs_next     = idle_cs;
                end
            end
        end else begin
            q_pop     = 1'b1;
            emit      = idle_emit;
            emit_wc   = idle_wc;
            emit_kind = idle_kind;
            if (idle_start) begin
                in_seq_next = 1'b1;
                rem_next    = idle_rem;
                code_next   = idle_code;
                cs_next     = idle_cs;
            end
        end

        proceed = q_valid && (!emit || out_free);
        q_pop   = q_pop && proceed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs1_len_reg <= '0;
            cs2_len_reg <= '0;
            cs3_len_reg <= '0;
            cs1_tag_reg <= CS1_TAG_RESET;
            cs2_tag_reg <= CS2_TAG_RESET;
            cs3_tag_reg <= CS3_TAG_RESET;
            in_seq_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_CS1_LEN: cs1_len_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_CS2_LEN: cs2_len_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_CS3_LEN: cs3_len_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_CS1_TAG: cs1_tag_reg <= cfg_wdata[WC_W-1:0];
                    CFG_CS2_TAG: cs2_tag_reg <= cfg_wdata[WC_W-1:0];
                    CFG_CS3_TAG: cs3_tag_reg <= cfg_wdata[WC_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (proceed) begin
                in_seq_reg <= in_seq_next;
            end
            if (proceed && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            rem_reg  <= rem_next;
            code_reg <= code_next;
            cs_reg   <= cs_next;
        end
        if (proceed && emit) begin
            wc_reg   <= emit_wc;
            kind_reg <= emit_kind;
            last_reg <= emit_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_wide_char   = wc_reg;
    assign m_kind        = kind_reg;
    assign m_last_of_run = last_reg;

    a_seq_has_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        in_seq_reg |-> (rem_reg != '0))
        else $error("sequence active with no bytes remaining");

    a_seq_has_codeset: assert property (@(posedge aclk) disable iff (!aresetn)
        in_seq_reg |-> (cs_reg != CS_NONE))
        else $error("sequence active without a codeset");

    a_split_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && emit && !emit_last) |=> (!in_seq_reg && q_valid))
        else $error("broken sequence did not return to idle with item held");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_wide_char) && $stable(m_kind)))
        else $error("stalled result overwritten");

endmodule

### design/euc_byte_to_wide_char_decoder.sv
// ============================================================================
// EUC byte to wide character decoder
// Decodes a stream of Extended Unix Code bytes into wide characters, with an
// illegal-sequence report when a multibyte sequence is broken.
// ============================================================================
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   s_byte_value, s_end_of_stream
//  m_       out        m_valid / m_ready   m_wide_char, m_kind, m_last_of_run
//  cfg_     in         cfg_write           cfg_index, cfg_wdata
//
//  One input transaction is taken per cycle while the queue has room.
//  An item that breaks a sequence and then yields its own character is held
//  at the queue head for a second pass, which bounds throughput for such items.
//  An input is stored in the queue, then its result is registered at the output.
//  The input side stalls only when the QUEUE_DEPTH entry queue is full.
//  Reset is synchronous; no clearing pass follows it.
// ============================================================================
module euc_byte_to_wide_char_decoder
    import eucdec_pkg::*;
#(
    parameter int BITS_PER_BYTE_CODE = 7,
    parameter int MAX_SEQ_LEN        = 4,
    parameter int QUEUE_DEPTH        = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_value,
    input  logic                 s_end_of_stream,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WC_W-1:0]      m_wide_char,
    output logic [1:0]           m_kind,
    output logic                 m_last_of_run
);

    logic  q_push;
    item_t q_push_item;
    logic  q_push_ready;
    logic  q_pop;
    logic  q_pop_valid;
    item_t q_pop_item;

    eucdec_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_end_of_stream (s_end_of_stream),
        .q_ready         (q_push_ready),
        .q_push          (q_push),
        .q_item          (q_push_item)
    );

    eucdec_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_item   (q_pop_item)
    );

    eucdec_back #(
        .BITS_PER_BYTE_CODE (BITS_PER_BYTE_CODE),
        .MAX_SEQ_LEN        (MAX_SEQ_LEN)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_pop_valid),
        .q_item        (q_pop_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_wide_char   (m_wide_char),
        .m_kind        (m_kind),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### tb/euc_byte_to_wide_char_decoder_tb.sv
// ============================================================================
// EUC decoder testbench
// Drives EUC bytes and end-of-stream marks into the decoder under random
// valid/ready gaps, including a long receiver hold-off that fills the
// internal queue. A directed table covers passthrough, single-byte codeset 1,
// and broken sequences. It is followed by randomized phases with mostly
// well-formed multibyte characters, under several length and tag settings.
// Every result is checked against a typed table row or an in-bench decoder model.
// ============================================================================
module euc_byte_to_wide_char_decoder_tb
    import eucdec_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_MAX         = 4;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int NUM_PHASES      = 12;
    localparam int PHASE_ITEMS     = 110;
    localparam int NUM_ROWS        = 29;

    typedef struct packed {
        logic [WC_W-1:0] wide_char;
        kind_t           kind;
        logic            last;
    } wres_t;

    typedef wres_t wres_pair_t [2];

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t         op;
        cfg_idx_t        idx;
        logic [CFG_W-1:0] data;
        logic            eos;
        logic [1:0]      n_typed;
        logic [WC_W-1:0] wc0;
        kind_t           k0;
        logic [WC_W-1:0] wc1;
        kind_t           k1;
    } drow_t;

    // Rows with n_typed of zero take their expectation from the decoder model.
    localparam drow_t DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM, CFG_CS1_LEN, 32'h00, 1'b0, 2'd1, 32'h00, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h7f, 1'b0, 2'd1, 32'h7f, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h80, 1'b0, 2'd1, 32'h80, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h9f, 1'b0, 2'd1, 32'h9f, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8e, 1'b0, 2'd1, 32'h8e, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8f, 1'b0, 2'd1, 32'h8f, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'ha0, 1'b0, 2'd1, 32'ha0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hff, 1'b0, 2'd1, 32'hff, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hff, 1'b1, 2'd1, 32'h00, KIND_EOS, 32'h0, KIND_CHAR},
        '{ROW_CFG, CFG_CS1_LEN, 32'h1, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hff, 1'b0, 2'd1, 32'h3000_007f, KIND_CHAR,
          32'h0, KIND_CHAR},
        '{ROW_CFG, CFG_CS1_LEN, 32'h2, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_CFG, CFG_CS2_LEN, 32'h2, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_CFG, CFG_CS3_LEN, 32'h3, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hb0, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hc1, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8e, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'ha1, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hff, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8f, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'ha0, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h41, 1'b0, 2'd2, 32'h0, KIND_ILLEGAL, 32'h41, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'hd0, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h00, 1'b1, 2'd2, 32'h0, KIND_ILLEGAL, 32'h0, KIND_EOS},
        '{ROW_ITEM, CFG_CS1_LEN, 32'he0, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h9f, 1'b0, 2'd2, 32'h0, KIND_ILLEGAL, 32'h9f, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8e, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h8f, 1'b0, 2'd0, 32'h0, KIND_CHAR, 32'h0, KIND_CHAR},
        '{ROW_ITEM, CFG_CS1_LEN, 32'h85, 1'b0, 2'd2, 32'h0, KIND_ILLEGAL, 32'h85, KIND_CHAR}
    };

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_write       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [CFG_W-1:0]     cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_byte_value    = '0;
    logic                 s_end_of_stream = 1'b0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [WC_W-1:0]      m_wide_char;
    logic [1:0]           m_kind;
    logic                 m_last_of_run;

    // Decoder model: configuration and sequence state.
    logic [LEN_W-1:0] cs1_len = '0;
    logic [LEN_W-1:0] cs2_len = '0;
    logic [LEN_W-1:0] cs3_len = '0;
    logic [WC_W-1:0]  cs1_tag = CS1_TAG_RESET;
    logic [WC_W-1:0]  cs2_tag = CS2_TAG_RESET;
    logic [WC_W-1:0]  cs3_tag = CS3_TAG_RESET;
    bit               seq_open = 1'b0;
    logic [2:0]       seq_left = '0;
    logic [27:0]      seq_code = '0;
    codeset_t         seq_cs   = CS_NONE;

    wres_t      awaited_q [$];
    wres_pair_t unused_pair;
    bit         steady_sender   = 1'b0;
    int         items_sent      = 0;
    int         reg_writes      = 0;
    int         results_checked = 0;
    int         mismatches      = 0;
    int         stall_cycles    = 0;

    euc_byte_to_wide_char_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_value    (s_byte_value),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wide_char     (m_wide_char),
        .m_kind          (m_kind),
        .m_last_of_run   (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 55) return 0;
        if (roll < 85) return int'($urandom_range(1, 3));
        if (roll < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
        return (n > LEN_W'(SEQ_MAX)) ? LEN_W'(SEQ_MAX) : n;
    endfunction

    function automatic void open_seq(input codeset_t cs, input logic [LEN_W-1:0] left,
                                     input logic [6:0] code);
        seq_open = 1'b1;
        seq_cs   = cs;
        seq_left = left;
        seq_code = 28'(code);
    endfunction

    function automatic bit decode_idle(input logic [7:0] b, input logic eos, output wres_t r);
        logic [LEN_W-1:0] rest;
        r    = '0;
        rest = clamp_len(cs1_len) - 1'b1;
        if (eos) begin
            r.kind = KIND_EOS;
            return 1'b1;
        end
        if (b < BYTE_C1_FIRST) begin
            r.wide_char = WC_W'(b);
            return 1'b1;
        end
        if (b == BYTE_SS2 && cs2_len != 0) begin
            open_seq(CS_TWO, clamp_len(cs2_len), 7'd0);
            return 1'b0;
        end
        if (b == BYTE_SS3 && cs3_len != 0) begin
            open_seq(CS_THREE, clamp_len(cs3_len), 7'd0);
            return 1'b0;
        end
        if (b <= BYTE_C1_LAST || cs1_len == 0) begin
            r.wide_char = WC_W'(b);
            return 1'b1;
        end
        if (rest == 0) begin
            r.wide_char = WC_W'(b[6:0]) | cs1_tag;
            return 1'b1;
        end
        open_seq(CS_ONE, rest, b[6:0]);
        return 1'b0;
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic eos,
                                        output wres_pair_t r, output int n);
        wres_t w;
        n    = 0;
        r[0] = '0;
        r[1] = '0;
        if (seq_open && (eos || b <= BYTE_C1_LAST)) begin
            r[0].kind = KIND_ILLEGAL;
            n         = 1;
            seq_open  = 1'b0;
            seq_left  = '0;
            seq_code  = '0;
            seq_cs    = CS_NONE;
            if (decode_idle(b, eos, w)) begin
                r[1] = w;
                n    = 2;
            end
        end else if (seq_open) begin
            seq_code = {seq_code[20:0], b[6:0]};
            seq_left = seq_left - 1'b1;
            if (seq_left == 0) begin
                r[0].wide_char = WC_W'(seq_code) | ((seq_cs == CS_TWO) ? cs2_tag :
                                 (seq_cs == CS_THREE) ? cs3_tag : cs1_tag);
                n        = 1;
                seq_open = 1'b0;
                seq_code = '0;
                seq_cs   = CS_NONE;
            end
        end else if (decode_idle(b, eos, w)) begin
            r[0] = w;
            n    = 1;
        end
        if (n > 0) r[n-1].last = 1'b1;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eos,
                             input int typed_n, input wres_pair_t typed_r);
        wres_pair_t r;
        int         n;
        int         gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_byte_value    <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        decode_step(b, eos, r, n);
        if (typed_n != 0) begin
            r = typed_r;
            n = typed_n;
        end
        for (int i = 0; i < n; i++) awaited_q.push_back(r[i]);
    endtask

    task automatic program_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        s_valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CS1_LEN: cs1_len = data[LEN_W-1:0];
            CFG_CS2_LEN: cs2_len = data[LEN_W-1:0];
            CFG_CS3_LEN: cs3_len = data[LEN_W-1:0];
            CFG_CS1_TAG: cs1_tag = data;
            CFG_CS2_TAG: cs2_tag = data;
            CFG_CS3_TAG: cs3_tag = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    initial begin : stimulus
        drow_t            row;
        wres_pair_t       typed;
        logic [LEN_W-1:0] l1, l2, l3;
        logic [WC_W-1:0]  t1, t2, t3;
        logic [LEN_W-1:0] tail;
        logic [7:0]       lead;
        codeset_t         cs;
        codeset_t         cands [$];
        int               pick;
        int               tail_n;
        int               sent;
        unused_pair[0] = '0;
        unused_pair[1] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.op == ROW_CFG) begin
                program_reg(row.idx, row.data);
            end else begin
                typed[0] = '{wide_char: row.wc0, kind: row.k0, last: row.n_typed == 2'd1};
                typed[1] = '{wide_char: row.wc1, kind: row.k1, last: 1'b1};
                send_item(row.data[7:0], row.eos, int'(row.n_typed), typed);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            l1 = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            l2 = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            l3 = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            t1 = $urandom();
            t2 = $urandom();
            t3 = $urandom();
            case (ph)
                0: begin
                    l1 = 3'd0; l2 = 3'd0; l3 = 3'd0;
                    t1 = '0;   t2 = '0;   t3 = '0;
                end
                1: begin
                    l1 = 3'd4; l2 = 3'd4; l3 = 3'd4;
                    t1 = '1;   t2 = '1;   t3 = '1;
                end
                2: begin
                    l1 = 3'd7; l2 = 3'd6; l3 = 3'd5;
                end
                3: begin
                    l1 = 3'd1; l2 = 3'd1; l3 = 3'd1;
                end
                default: ;
            endcase
            program_reg(CFG_CS1_LEN, {29'($urandom()), l1});
            program_reg(CFG_CS2_LEN, {29'($urandom()), l2});
            program_reg(CFG_CS3_LEN, {29'($urandom()), l3});
            program_reg(CFG_CS1_TAG, t1);
            program_reg(CFG_CS2_TAG, t2);
            program_reg(CFG_CS3_TAG, t3);
            steady_sender = (ph % 4 == 3);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 75) begin
                    cands.delete();
                    if (cs1_len != 0) cands.push_back(CS_ONE);
                    if (cs2_len != 0) cands.push_back(CS_TWO);
                    if (cs3_len != 0) cands.push_back(CS_THREE);
                    if (cands.size() == 0) begin
                        send_item(8'($urandom_range(0, 255)), 1'b0, 0, unused_pair);
                        sent++;
                    end else begin
                        cs = cands[$urandom_range(0, cands.size() - 1)];
                        case (cs)
                            CS_TWO: begin
                                lead = BYTE_SS2;
                                tail = clamp_len(cs2_len);
                            end
                            CS_THREE: begin
                                lead = BYTE_SS3;
                                tail = clamp_len(cs3_len);
                            end
                            default: begin
                                lead = 8'($urandom_range(8'ha0, 8'hff));
                                tail = clamp_len(cs1_len) - 1'b1;
                            end
                        endcase
                        // Broken sequences stop short and end on a byte that cannot continue.
                        if (pick >= 60 && tail != 0) tail_n = int'($urandom_range(0, tail - 1));
                        else tail_n = int'(tail);
                        send_item(lead, 1'b0, 0, unused_pair);
                        sent++;
                        repeat (tail_n) begin
                            send_item(8'($urandom_range(8'ha0, 8'hff)), 1'b0, 0, unused_pair);
                            sent++;
                        end
                        if (pick >= 60) begin
                            if ($urandom_range(0, 2) == 0)
                                send_item(8'($urandom_range(0, 255)), 1'b1, 0, unused_pair);
                            else
                                send_item(8'($urandom_range(0, 8'h9f)), 1'b0, 0, unused_pair);
                            sent++;
                        end
                    end
                end else if (pick < 85) begin
                    send_item(8'($urandom_range(0, 8'h9f)), 1'b0, 0, unused_pair);
                    sent++;
                end else if (pick < 92) begin
                    send_item(8'($urandom_range(0, 255)), 1'b1, 0, unused_pair);
                    sent++;
                end else begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 0, unused_pair);
                    sent++;
                end
            end
        end

        s_valid <= 1'b0;
        while (awaited_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += awaited_q.size();
        $display("summary: %0d bytes and end marks over %0d setting phases, %0d register writes",
                 items_sent, NUM_PHASES + 1, reg_writes);
        $display("summary: %0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Receiver ready pattern, with one long hold-off so the input side backs up.
    initial begin : receiver
        int  n;
        bit  held;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && results_checked >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        wres_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles = stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end else if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result: wide_char=%h kind=%0d last=%b",
                                            m_wide_char, m_kind, m_last_of_run));
                end else begin
                    want = awaited_q.pop_front();
                    results_checked++;
                    if (m_wide_char !== want.wide_char || m_kind !== 2'(want.kind) ||
                        m_last_of_run !== want.last) begin
                        note_mismatch($sformatf(
                            "result %0d: expected wide_char=%h kind=%0d last=%b, got %h %0d %b",
                            results_checked, want.wide_char, want.kind, want.last,
                            m_wide_char, m_kind, m_last_of_run));
                    end
                end
            end
        end
    end

endmodule
